>>> hw/rtl/lcg48_pkg.sv
// Shared constants for the 48-bit linear congruential generator.
// Used by lcg48_random_generator_top and its port checker; no dependencies.
package lcg48_pkg;

    localparam int SEED_W      = 48;
    localparam int MULT_BITS   = 35;
    localparam int S_TDATA_W   = 88;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 64;

    localparam logic [SEED_W-1:0]    LCG_MULT = 48'h0005_DEEC_E66D;
    localparam logic [SEED_W-1:0]    LCG_INC  = 48'h0000_0000_000B;

    typedef enum logic [S_TUSER_W-1:0] {
        CMD_RESEED  = 2'd0,
        CMD_NEXT    = 2'd1,
        CMD_BOUNDED = 2'd2,
        CMD_LONG    = 2'd3
    } cmd_t;

endpackage

>>> hw/rtl/lcg48_random_generator_top.sv
// Reseed and a bound of zero or less go straight to the done state; next and bounded draws
// advance the seed once, long twice; next then shifts the top bits down, a bounded draw with a
// bound of 2^k shifts, else it divides and advances again for each rejected try.
// A seed advance is a bit-serial multiply over the 35 multiplier bits; the modulo
// is a restoring divider, one quotient bit per cycle, followed by a reject check.
// One request at a time: s_tready is high only when idle, after the result is registered;
// reset (aresetn low at a clock edge) sets the seed to 0x5DEECE66D and empties the output.
module lcg48_random_generator_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // seed_in [47:0], bits [53:48], bound [85:54], zero fill [87:86]
    input  logic [lcg48_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd [1:0]
    input  logic [lcg48_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // value [63:0]
    output logic [lcg48_pkg::M_TDATA_W-1:0]   m_tdata
);
    import lcg48_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_DRAW = 7'b0000100,
        ST_NEXT = 7'b0001000,
        ST_POW2 = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [5:0]              cnt_reg, cnt_next;
    logic [SEED_W-1:0]       seed_reg, seed_next;
    logic [SEED_W-1:0]       acc_reg, acc_next;
    logic [SEED_W-1:0]       seed_sh_reg, seed_sh_next;
    logic [MULT_BITS-1:0]    mult_sh_reg, mult_sh_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [5:0]              nbits_reg, nbits_next;
    logic [31:0]             bound_reg, bound_next;
    logic                    first_reg, first_next;
    logic [31:0]             hi_reg, hi_next;
    logic [31:0]             work_reg, work_next;
    logic [30:0]             r_reg, r_next;
    logic [30:0]             rem_reg, rem_next;
    logic [M_TDATA_W-1:0]    res_reg, res_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    logic [SEED_W-1:0]       acc_sum;
    logic [31:0]             rem_sh;
    logic [31:0]             bound_pos;
    logic                    rem_ge;
    logic [31:0]             reject_sum;
    logic [5:0]              nbits_sat;
    logic                    bound_pow2;
    logic [31:0]             in_bound;

    assign in_bound   = s_tdata[85:54];
    assign acc_sum    = acc_reg + (mult_sh_reg[0] ? seed_sh_reg : '0);
    assign bound_pos  = {1'b0, bound_reg[30:0]};
    assign rem_sh     = {rem_reg, work_reg[30]};
    assign rem_ge     = rem_sh >= bound_pos;
    // The draw is rejected when r - v + bound - 1 wraps negative in 32 bits.
    assign reject_sum = {1'b0, r_reg} - {1'b0, rem_reg} + bound_reg - 32'd1;
    assign nbits_sat  = (nbits_reg > 6'd32) ? 6'd32 : nbits_reg;
    assign bound_pow2 = (bound_reg & (32'd0 - bound_reg)) == bound_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        seed_next     = seed_reg;
        acc_next      = acc_reg;
        seed_sh_next  = seed_sh_reg;
        mult_sh_next  = mult_sh_reg;
        cmd_next      = cmd_reg;
        nbits_next    = nbits_reg;
        bound_next    = bound_reg;
        first_next    = first_reg;
        hi_next       = hi_reg;
        work_next     = work_reg;
        r_next        = r_reg;
        rem_next      = rem_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next     = cmd_t'(s_tuser);
                    nbits_next   = s_tdata[53:48];
                    bound_next   = in_bound;
                    first_next   = 1'b1;
                    acc_next     = LCG_INC;
                    seed_sh_next = seed_reg;
                    mult_sh_next = LCG_MULT[MULT_BITS-1:0];
                    cnt_next     = 6'(MULT_BITS - 1);
                    res_next     = '0;
                    unique case (cmd_t'(s_tuser))
                        CMD_RESEED: begin
                            seed_next  = s_tdata[SEED_W-1:0] ^ LCG_MULT;
                            state_next = ST_DONE;
                        end
                        CMD_BOUNDED: begin
                            // A bound of zero or less returns 0 and leaves the seed.
                            if (in_bound[31] || in_bound == 32'd0) begin
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_MUL;
                            end
                        end
                        default: begin
                            state_next = ST_MUL;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                acc_next     = acc_sum;
                seed_sh_next = {seed_sh_reg[SEED_W-2:0], 1'b0};
                mult_sh_next = {1'b0, mult_sh_reg[MULT_BITS-1:1]};
                if (cnt_reg == 6'd0) begin
                    seed_next  = acc_sum;
                    state_next = ST_DRAW;
                end else begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            ST_DRAW: begin
                acc_next     = LCG_INC;
                seed_sh_next = seed_reg;
                mult_sh_next = LCG_MULT[MULT_BITS-1:0];
                cnt_next     = 6'(MULT_BITS - 1);
                unique case (cmd_reg)
                    CMD_NEXT: begin
                        if (nbits_reg == 6'd0) begin
                            res_next   = '0;
                            state_next = ST_DONE;
                        end else begin
                            work_next  = seed_reg[47:16];
                            cnt_next   = 6'd32 - nbits_sat;
                            state_next = ST_NEXT;
                        end
                    end
                    CMD_LONG: begin
                        if (first_reg) begin
                            hi_next    = seed_reg[47:16];
                            first_next = 1'b0;
                            state_next = ST_MUL;
                        end else begin
                            // The low half is unsigned, so no carry reaches the high half.
                            res_next   = {hi_reg, seed_reg[47:16]};
                            state_next = ST_DONE;
                        end
                    end
                    CMD_BOUNDED: begin
                        r_next    = seed_reg[47:17];
                        work_next = {1'b0, seed_reg[47:17]};
                        if (bound_pow2) begin
                            state_next = ST_POW2;
                        end else begin
                            rem_next   = '0;
                            cnt_next   = 6'd30;
                            state_next = ST_DIV;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_NEXT: begin
                if (cnt_reg == 6'd0) begin
                    res_next   = {{32{work_reg[31]}}, work_reg};
                    state_next = ST_DONE;
                end else begin
                    work_next = {1'b0, work_reg[31:1]};
                    cnt_next  = cnt_reg - 6'd1;
                end
            end
            ST_POW2: begin
                // (bound * r) >> 31 for bound = 2^k: shift r right until the bound reaches bit 31.
                if (bound_reg[31]) begin
                    res_next   = {32'd0, work_reg};
                    state_next = ST_DONE;
                end else begin
                    work_next  = {1'b0, work_reg[31:1]};
                    bound_next = {bound_reg[30:0], 1'b0};
                end
            end
            ST_DIV: begin
                work_next = {work_reg[30:0], 1'b0};
                rem_next  = rem_ge ? 31'(rem_sh - bound_pos) : rem_sh[30:0];
                if (cnt_reg == 6'd0) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg - 6'd1;
                end
                if (cnt_reg == 6'd0) begin
                    // The remainder is checked for rejection on the next cycle.
                    state_next = ST_DIV;
                    cnt_next   = 6'd63;
                end
                if (cnt_reg == 6'd63) begin
                    work_next = work_reg;
                    rem_next  = rem_reg;
                    if (reject_sum[31]) begin
                        state_next = ST_MUL;
                        cnt_next   = 6'(MULT_BITS - 1);
                    end else begin
                        res_next   = {33'd0, rem_reg};
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            seed_reg     <= LCG_MULT;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            seed_reg     <= seed_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        acc_reg     <= acc_next;
        seed_sh_reg <= seed_sh_next;
        mult_sh_reg <= mult_sh_next;
        cmd_reg     <= cmd_next;
        nbits_reg   <= nbits_next;
        bound_reg   <= bound_next;
        first_reg   <= first_next;
        hi_reg      <= hi_next;
        work_reg    <= work_next;
        r_reg       <= r_next;
        rem_reg     <= rem_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> hw/rtl/lcg48_checker.sv
// Port-level checker for lcg48_random_generator_top, attached by bind below.
// Depends on lcg48_pkg for port widths.
module lcg48_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [lcg48_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [lcg48_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [lcg48_pkg::M_TDATA_W-1:0]   m_tdata
);
    import lcg48_pkg::*;

    logic [1:0] owed_reg, owed_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // Count of accepted requests whose result beat has not left yet.
    always_comb begin
        owed_next = owed_reg + {1'b0, in_beat} - {1'b0, out_beat};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owed_reg <= '0;
        end else begin
            owed_reg <= owed_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("request beat dropped or changed while waiting");

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> !s_tready)
        else $error("request taken while another is in work");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> owed_reg != 2'd0)
        else $error("result beat without an accepted request");

    a_ready_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> owed_reg <= 2'd1)
        else $error("ready while more than one result is owed");

endmodule

bind lcg48_random_generator_top lcg48_checker u_lcg48_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> dv/lcg48_random_generator_top_tb.sv
// Self-checking testbench for lcg48_random_generator_top: directed and random requests
// checked against a bit-exact model of the 48-bit generator kept in this file.
// Depends on lcg48_pkg and the top-level RTL only.
module lcg48_random_generator_top_tb;
    import lcg48_pkg::*;

    localparam int ITEMS_PER_CHUNK = 244;
    localparam int CHUNK_COUNT     = 8;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int DRAIN_CYCLES    = 200;

    typedef struct {
        cmd_t              cmd;
        logic [SEED_W-1:0] seed;
        logic [5:0]        nbits;
        logic [31:0]       bound;
    } gen_req_t;

    typedef struct {
        cmd_t        cmd;
        logic [63:0] value;
    } draw_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // seed_in [47:0], bits [53:48], bound [85:54], zero fill [87:86]
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // cmd [1:0]
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // value [63:0]
    logic [M_TDATA_W-1:0] m_tdata;

    gen_req_t          req_q[$];
    draw_t             draw_q[$];
    logic [SEED_W-1:0] seed_model = LCG_MULT;
    int                src_idle_pct   = 0;
    int                sink_stall_pct = 0;
    int                hold_req  = 0;
    int                hold_ack  = 0;
    int                hold_left = 0;
    logic              s_taken   = 1'b0;
    int                err_cnt   = 0;
    int                idle_cycles = 0;

    lcg48_random_generator_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // One seed advance; returns the top nbits of the new seed (saturated at 32).
    function automatic logic [31:0] advance_seed(int unsigned nbits);
        seed_model = seed_model * LCG_MULT + LCG_INC;
        if (nbits == 0)
            return '0;
        if (nbits > 32)
            nbits = 32;
        return 32'(seed_model >> (48 - nbits));
    endfunction

    function automatic logic [63:0] bounded_draw(logic [31:0] bound);
        logic [31:0] r;
        logic [31:0] v;
        logic [31:0] t;
        logic [63:0] prod;
        if (bound == 0 || bound[31])
            return '0;
        if ((bound & (~bound + 32'd1)) == bound) begin
            r = advance_seed(31);
            prod = {32'd0, bound} * {32'd0, r};
            return prod >> 31;
        end
        r = advance_seed(31);
        v = r % bound;
        t = r - v + bound - 32'd1;
        // The rejection test wraps at 32 bits, so a set sign bit means retry.
        while (t[31]) begin
            r = advance_seed(31);
            v = r % bound;
            t = r - v + bound - 32'd1;
        end
        return {32'd0, v};
    endfunction

    function automatic logic [63:0] predict_draw(cmd_t cmd, logic [SEED_W-1:0] seed,
                                                 logic [5:0] nbits, logic [31:0] bound);
        logic [31:0] hi;
        logic [31:0] lo;
        case (cmd)
            CMD_RESEED: begin
                seed_model = seed ^ LCG_MULT;
                return '0;
            end
            CMD_NEXT: begin
                hi = advance_seed(nbits);
                return {{32{hi[31]}}, hi};
            end
            CMD_BOUNDED: return bounded_draw(bound);
            CMD_LONG: begin
                hi = advance_seed(32);
                lo = advance_seed(32);
                return {hi, lo};
            end
        endcase
        return '0;
    endfunction

    function automatic gen_req_t random_req();
        gen_req_t    r;
        int unsigned pick;
        pick = $urandom_range(99);
        r.cmd = pick < 10 ? CMD_RESEED : pick < 40 ? CMD_NEXT : pick < 80 ? CMD_BOUNDED : CMD_LONG;
        r.seed = {16'($urandom()), 32'($urandom())};
        r.nbits = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(1, 32));
        case ($urandom_range(9))
            0: r.bound = '0;
            1: r.bound = 32'h8000_0000 | $urandom();
            2: r.bound = 32'd1 << $urandom_range(30);
            3: r.bound = $urandom_range(1, 100);
            // Just above 2^30 the rejection loop retries about half the time.
            4: r.bound = 32'h4000_0000 + $urandom_range(1, 32'h0FFF_FFFF);
            5, 6, 7: r.bound = $urandom() & 32'h7FFF_FFFF;
            default: r.bound = $urandom();
        endcase
        return r;
    endfunction

    task automatic queue_req(cmd_t cmd, logic [SEED_W-1:0] seed, logic [5:0] nbits,
                             logic [31:0] bound);
        gen_req_t r;
        r.cmd = cmd;
        r.seed = seed;
        r.nbits = nbits;
        r.bound = bound;
        req_q.push_back(r);
    endtask

    task automatic wait_drained();
        while (req_q.size() != 0 || s_tvalid || draw_q.size() != 0)
            @(posedge aclk);
    endtask

    // Request driver.
    always @(negedge aclk) begin
        gen_req_t req;
        if (aresetn && (!s_tvalid || s_taken)) begin
            if (req_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                req = req_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= req.cmd;
                s_tdata  <= {2'b00, req.bound, req.nbits, req.seed};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver; a hold request keeps m_tready low for a long stretch.
    always @(negedge aclk) begin
        if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Checks each result beat, then predicts for a request beat taken at this edge.
    always @(posedge aclk) begin
        draw_t want;
        s_taken <= s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (draw_q.size() == 0) begin
                err_cnt++;
                $error("value: result beat with no request waiting, actual %h", m_tdata);
            end else begin
                want = draw_q.pop_front();
                if (m_tdata !== want.value) begin
                    err_cnt++;
                    $error("value mismatch on %s: expected %h, actual %h",
                           want.cmd.name(), want.value, m_tdata);
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            want.cmd = cmd_t'(s_tuser);
            want.value = predict_draw(want.cmd, s_tdata[47:0], s_tdata[53:48], s_tdata[85:54]);
            draw_q.push_back(want);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The first draw checks the seed left by reset.
        queue_req(CMD_NEXT,    48'h1234_5678_9ABC, 6'd32, 32'hDEAD_BEEF);
        queue_req(CMD_NEXT,    48'h0,              6'd0,  32'h0);
        queue_req(CMD_NEXT,    48'hFFFF_FFFF_FFFF, 6'd1,  32'hFFFF_FFFF);
        queue_req(CMD_NEXT,    48'h0,              6'd31, 32'h0);
        queue_req(CMD_NEXT,    48'h0,              6'd33, 32'h0);
        queue_req(CMD_NEXT,    48'h0,              6'd63, 32'h0);
        queue_req(CMD_NEXT,    48'h0,              6'd24, 32'h0);
        queue_req(CMD_BOUNDED, 48'hFFFF_FFFF_FFFF, 6'd63, 32'h0);
        queue_req(CMD_BOUNDED, 48'h0,              6'd0,  32'hFFFF_FFFF);
        queue_req(CMD_BOUNDED, 48'h0,              6'd0,  32'h8000_0000);
        queue_req(CMD_BOUNDED, 48'h0,              6'd0,  32'h0000_0001);
        queue_req(CMD_BOUNDED, 48'h0,              6'd0,  32'h4000_0000);
        queue_req(CMD_BOUNDED, 48'h0,              6'd0,  32'h7FFF_FFFF);
        queue_req(CMD_BOUNDED, 48'h0,              6'd0,  32'h4000_0001);
        queue_req(CMD_BOUNDED, 48'h0,              6'd0,  32'h0000_0003);
        queue_req(CMD_LONG,    48'hFFFF_FFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
        queue_req(CMD_RESEED,  48'h0,              6'd63, 32'hFFFF_FFFF);
        queue_req(CMD_LONG,    48'h0,              6'd0,  32'h0);
        queue_req(CMD_RESEED,  48'hFFFF_FFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
        queue_req(CMD_NEXT,    48'h0,              6'd32, 32'h0);
        queue_req(CMD_BOUNDED, 48'hFFFF_FFFF_FFFF, 6'd63, 32'h0000_0006);
        // This seed cancels the scramble, so the generator runs from zero.
        queue_req(CMD_RESEED,  LCG_MULT,           6'd0,  32'h0);
        queue_req(CMD_NEXT,    48'h0,              6'd32, 32'h0);
        queue_req(CMD_LONG,    48'h0,              6'd0,  32'h0);
        wait_drained();

        for (int chunk = 0; chunk < CHUNK_COUNT; chunk++) begin
            case (chunk % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 79; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 79; end
                default: begin src_idle_pct = 31; sink_stall_pct = 31; end
            endcase
            // Stall the output while requests keep coming so the input backs up.
            if (chunk == 0)
                hold_req++;
            repeat (ITEMS_PER_CHUNK) req_q.push_back(random_req());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (draw_q.size() != 0)
            $error("value: %0d expected results never arrived", draw_q.size());
        if (err_cnt == 0 && draw_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
